>>> hdl/pmal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak meter package
// Shared widths, constants and payload types of the peak meter.
// ----------------------------------------------------------------------------
package pmal_pkg;

    localparam int SAMPLE_W         = 24;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int CH_FIELD_W       = 3;
    localparam int DB_W             = 16;
    localparam int CFG_CH_W         = 4;
    localparam int ALPHA_W          = 16;
    localparam int TICKS_W          = 8;
    localparam int FRAC_BITS        = 30;
    localparam int EXP_W            = 5;
    localparam int LOG_W            = EXP_W + FRAC_BITS;
    localparam int QUEUE_DEPTH      = 4;
    localparam int PEAK_FLOOR       = (1 << (SAMPLE_W - 1)) / 1000000;

    localparam logic signed [DB_W-1:0] DB_FLOOR = -16'sd24576;
    localparam logic signed [DB_W:0]   DB_GATE  = -17'sd24320;
    localparam logic [26:0]            DB_PER_LOG2_Q16 = 27'd101008905;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_TICK   = 1'b1;

    localparam logic [1:0] REG_CHANNELS     = 2'd0;
    localparam logic [1:0] REG_ALPHA_START  = 2'd1;
    localparam logic [1:0] REG_ALPHA_STEADY = 2'd2;
    localparam logic [1:0] REG_START_TICKS  = 2'd3;

    typedef struct packed {
        logic                       operation;
        logic [CH_FIELD_W-1:0]      channel;
        logic signed [SAMPLE_W-1:0] sample;
        logic                       buffer_end;
    } pmal_in_t;

    typedef struct packed {
        logic [CH_FIELD_W-1:0]  out_channel;
        logic [SAMPLE_W-1:0]    peak;
        logic signed [DB_W-1:0] ambient_db;
        logic                   has_channels;
        logic                   last_of_report;
    } pmal_out_t;

    typedef struct packed {
        logic                  is_tick;
        logic [CH_FIELD_W-1:0] ch;
        logic [SAMPLE_W-1:0]   mag;
        logic                  buffer_end;
    } pmal_cmd_t;

    typedef struct packed {
        logic [CFG_CH_W-1:0] channels;
        logic [ALPHA_W-1:0]  alpha_start;
        logic [ALPHA_W-1:0]  alpha_steady;
        logic [TICKS_W-1:0]  start_ticks;
    } pmal_cfg_t;

endpackage

>>> hdl/pmal_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak meter front end
// Accepts items, drops samples of unused channels and rectifies samples.
// ----------------------------------------------------------------------------
module pmal_front #(
    parameter int MAX_CHANNELS = pmal_pkg::MAX_CHANNELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pmal_pkg::pmal_in_t  s_data,
    input  pmal_pkg::pmal_cfg_t cfg,
    output logic                cmd_valid,
    input  logic                cmd_ready,
    output pmal_pkg::pmal_cmd_t cmd
);
    import pmal_pkg::*;

    logic        valid_reg;
    pmal_cmd_t   cmd_reg;
    pmal_cmd_t   cmd_next;
    logic [4:0]  active;
    logic        keep;

    assign active = ({1'b0, cfg.channels} > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS)
                                                             : {1'b0, cfg.channels};
    assign keep = (s_data.operation == OP_TICK) || ({2'b00, s_data.channel} < active);

    always_comb begin
        cmd_next.is_tick    = (s_data.operation == OP_TICK);
        cmd_next.ch         = s_data.channel;
        cmd_next.mag        = s_data.sample[SAMPLE_W-1] ? (~s_data.sample + 1'b1)
                                                        : s_data.sample;
        cmd_next.buffer_end = s_data.buffer_end;
    end

    assign s_ready   = !valid_reg || cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid && keep;
            if (s_valid) begin
                cmd_reg <= cmd_next;
            end
        end
    end

endmodule

>>> hdl/pmal_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak meter command queue
// Short first-in first-out queue between the front end and the back end.
// ----------------------------------------------------------------------------
module pmal_queue (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    output logic                push_ready,
    input  pmal_pkg::pmal_cmd_t push_data,
    output logic                pop_valid,
    input  logic                pop_ready,
    output pmal_pkg::pmal_cmd_t pop_data
);
    import pmal_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    pmal_cmd_t        mem_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = mem_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> hdl/pmal_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak meter back end
// Updates channel peaks, computes the ambient level and sends tick reports.
// ----------------------------------------------------------------------------
module pmal_back #(
    parameter int MAX_CHANNELS = pmal_pkg::MAX_CHANNELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                cmd_valid,
    output logic                cmd_ready,
    input  pmal_pkg::pmal_cmd_t cmd,
    input  pmal_pkg::pmal_cfg_t cfg,
    output logic                m_valid,
    input  logic                m_ready,
    output pmal_pkg::pmal_out_t m_data
);
    import pmal_pkg::*;

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
    localparam logic [LOG_W-1:0] LOG_TOP = LOG_W'(SAMPLE_W - 1) << FRAC_BITS;

    typedef enum logic [2:0] {
        ST_IDLE, ST_NORM, ST_SQUARE, ST_MUL, ST_SUM, ST_SMUL, ST_SADD, ST_REPORT
    } state_t;

    state_t                 state_reg;
    logic [SAMPLE_W-1:0]    running_reg [MAX_CHANNELS];
    logic [SAMPLE_W-1:0]    latest_reg  [MAX_CHANNELS];
    logic [CNT_W-1:0]       rep_cnt_reg;
    logic signed [DB_W-1:0] amb_reg;
    logic [TICKS_W-1:0]     tick_cnt_reg;
    logic [ALPHA_W-1:0]     alpha_reg;
    logic [31:0]            x_reg;
    logic [EXP_W-1:0]       e_reg;
    logic [FRAC_BITS-1:0]   frac_reg;
    logic [4:0]             step_reg;
    logic [44:0]            plo_reg;
    logic [43:0]            phi_reg;
    logic signed [DB_W:0]   lvl_reg;
    logic [32:0]            prod_reg;
    logic                   neg_reg;
    logic [CNT_W-1:0]       idx_reg;
    logic [CNT_W-1:0]       n_reg;
    logic                   m_valid_reg;
    pmal_out_t              m_data_reg;

    logic [4:0]             active;
    logic [CH_W-1:0]        ch;
    logic [SAMPLE_W-1:0]    peak_next;
    logic [63:0]            sq;
    logic [32:0]            sq_top;
    logic [LOG_W-1:0]       lg;
    logic [LOG_W-1:0]       log_dist;
    logic [62:0]            sum;
    logic signed [DB_W:0]   lvl_next;
    logic signed [DB_W:0]   diff;
    logic [DB_W:0]          absd;
    logic [33:0]            rnd;
    logic [DB_W:0]          stp;
    logic                   last;
    logic                   out_load;

    assign active = ({1'b0, cfg.channels} > 5'(MAX_CHANNELS)) ? 5'(MAX_CHANNELS)
                                                             : {1'b0, cfg.channels};
    assign ch        = CH_W'(cmd.ch);
    assign peak_next = (cmd.mag > running_reg[ch]) ? cmd.mag : running_reg[ch];
    assign sq        = 64'(x_reg) * 64'(x_reg);
    assign sq_top    = sq[63:31];
    assign lg        = {e_reg, frac_reg};
    assign log_dist  = (lg >= LOG_TOP) ? '0 : LOG_TOP - lg;
    assign sum       = 63'(plo_reg) + 63'({phi_reg, 18'b0}) + (63'(1) << 45);
    assign lvl_next  = -$signed({1'b0, sum[61:46]});
    assign diff      = lvl_reg - $signed({amb_reg[DB_W-1], amb_reg});
    assign absd      = diff[DB_W] ? 17'(-diff) : 17'(diff);
    assign rnd       = 34'(prod_reg) + 34'd32768;
    assign stp       = rnd[32:16];
    assign last      = (n_reg == '0) || (idx_reg == n_reg - 1'b1);
    assign out_load  = (state_reg == ST_REPORT) && (!m_valid_reg || m_ready);

    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            rep_cnt_reg  <= '0;
            amb_reg      <= DB_FLOOR;
            tick_cnt_reg <= '0;
            m_valid_reg  <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++) begin
                running_reg[i] <= '0;
                latest_reg[i]  <= '0;
            end
        end else begin
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (cmd_valid && !cmd.is_tick) begin
                        if (cmd.buffer_end) begin
                            latest_reg[ch]  <= peak_next;
                            running_reg[ch] <= '0;
                            rep_cnt_reg     <= CNT_W'(active);
                        end else begin
                            running_reg[ch] <= peak_next;
                        end
                    end else if (cmd_valid) begin
                        n_reg     <= rep_cnt_reg;
                        idx_reg   <= '0;
                        alpha_reg <= (tick_cnt_reg < cfg.start_ticks) ? cfg.alpha_start
                                                                      : cfg.alpha_steady;
                        if (tick_cnt_reg < cfg.start_ticks) begin
                            tick_cnt_reg <= tick_cnt_reg + 1'b1;
                        end
                        x_reg <= 32'(latest_reg[0]);
                        e_reg <= 5'd31;
                        if (rep_cnt_reg == '0 ||
                            latest_reg[0] <= SAMPLE_W'(PEAK_FLOOR)) begin
                            state_reg <= ST_REPORT;
                        end else begin
                            state_reg <= ST_NORM;
                        end
                    end
                end
                ST_NORM: begin
                    if (x_reg[31]) begin
                        step_reg  <= '0;
                        frac_reg  <= '0;
                        state_reg <= ST_SQUARE;
                    end else begin
                        x_reg <= {x_reg[30:0], 1'b0};
                        e_reg <= e_reg - 1'b1;
                    end
                end
                ST_SQUARE: begin
                    frac_reg <= {frac_reg[FRAC_BITS-2:0], sq_top[32]};
                    x_reg    <= sq_top[32] ? sq_top[32:1] : sq_top[31:0];
                    step_reg <= step_reg + 1'b1;
                    if (step_reg == 5'(FRAC_BITS - 1)) begin
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    plo_reg   <= 45'(log_dist[17:0]) * 45'(DB_PER_LOG2_Q16);
                    phi_reg   <= 44'(log_dist[LOG_W-1:18]) * 44'(DB_PER_LOG2_Q16);
                    state_reg <= ST_SUM;
                end
                ST_SUM: begin
                    lvl_reg   <= lvl_next;
                    state_reg <= (lvl_next > DB_GATE) ? ST_SMUL : ST_REPORT;
                end
                ST_SMUL: begin
                    prod_reg  <= 33'(absd) * 33'(alpha_reg);
                    neg_reg   <= diff[DB_W];
                    state_reg <= ST_SADD;
                end
                ST_SADD: begin
                    amb_reg   <= neg_reg ? amb_reg - DB_W'(stp) : amb_reg + DB_W'(stp);
                    state_reg <= ST_REPORT;
                end
                ST_REPORT: begin
                    if (out_load) begin
                        m_data_reg.out_channel     <= CH_FIELD_W'(idx_reg);
                        m_data_reg.peak            <= (n_reg == '0) ? '0
                                                    : latest_reg[CH_W'(idx_reg)];
                        m_data_reg.ambient_db      <= amb_reg;
                        m_data_reg.has_channels    <= (n_reg != '0);
                        m_data_reg.last_of_report  <= last;
                        idx_reg                    <= idx_reg + 1'b1;
                        if (last) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule

>>> hdl/peak_meter_with_ambient_level.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak meter with ambient level
// Per-channel absolute peak meter with a smoothed ambient level in dBFS.
// ----------------------------------------------------------------------------
// Sample and tick items enter on the s_ channel. A sample updates the running
// peak of its channel, and a buffer end makes it the channel's latest peak.
// A tick produces one result item per reported channel (one empty item if none
// is reported) on the m_ channel, all carrying the ambient level after this tick.
// A sample item is handled in the back end's idle state, so samples stream at one per
// cycle while no tick is in progress. A tick goes straight to its report when no
// channel has been reported or channel 0 is at or below the level floor, otherwise
// through normalization and bitwise log2 squaring on one multiplier, then scaling and,
// above the gate, smoothing, then one result item per cycle while the receiver is ready.
// A four-item queue between front and back end keeps the input open while a
// tick is in progress or the receiver stalls; a stalled result is held.
// Reset clears all peaks, the tick count and the ambient level to -96 dB and
// restores the register defaults. Registers are on an APB port at 4*index.
// ----------------------------------------------------------------------------
module peak_meter_with_ambient_level #(
    parameter int MAX_CHANNELS = pmal_pkg::MAX_CHANNELS_DEF
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pmal_pkg::pmal_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output pmal_pkg::pmal_out_t m_data,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);
    import pmal_pkg::*;

    pmal_cfg_t cfg_reg;
    pmal_cmd_t front_cmd;
    pmal_cmd_t queue_cmd;
    logic      front_valid;
    logic      front_ready;
    logic      queue_valid;
    logic      queue_ready;

    assign pready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.channels     <= 4'd1;
            cfg_reg.alpha_start  <= 16'd26214;
            cfg_reg.alpha_steady <= 16'd655;
            cfg_reg.start_ticks  <= 8'd6;
        end else if (psel && penable && pwrite && pready) begin
            unique case (paddr[3:2])
                REG_CHANNELS:     cfg_reg.channels     <= pwdata[CFG_CH_W-1:0];
                REG_ALPHA_START:  cfg_reg.alpha_start  <= pwdata[ALPHA_W-1:0];
                REG_ALPHA_STEADY: cfg_reg.alpha_steady <= pwdata[ALPHA_W-1:0];
                REG_START_TICKS:  cfg_reg.start_ticks  <= pwdata[TICKS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[3:2])
            REG_CHANNELS:     prdata = 32'(cfg_reg.channels);
            REG_ALPHA_START:  prdata = 32'(cfg_reg.alpha_start);
            REG_ALPHA_STEADY: prdata = 32'(cfg_reg.alpha_steady);
            REG_START_TICKS:  prdata = 32'(cfg_reg.start_ticks);
            default:          prdata = '0;
        endcase
    end

    pmal_front #(.MAX_CHANNELS(MAX_CHANNELS)) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg       (cfg_reg),
        .cmd_valid (front_valid),
        .cmd_ready (front_ready),
        .cmd       (front_cmd)
    );

    pmal_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_data  (front_cmd),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_data   (queue_cmd)
    );

    pmal_back #(.MAX_CHANNELS(MAX_CHANNELS)) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (queue_valid),
        .cmd_ready (queue_ready),
        .cmd       (queue_cmd),
        .cfg       (cfg_reg),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

>>> hdl/pmal_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak meter checker
// Port-level checks of the result channel and the register port.
// ----------------------------------------------------------------------------
module pmal_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                m_valid,
    input logic                m_ready,
    input pmal_pkg::pmal_out_t m_data,
    input logic                pready
);
    import pmal_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Stalled result item changed.");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result item valid right after reset.");

    a_empty_report: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.has_channels |->
            m_data.last_of_report && m_data.peak == '0 && m_data.out_channel == '0)
        else $error("Empty report item is malformed.");

    a_level_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.ambient_db <= 0 && m_data.ambient_db >= DB_FLOOR)
        else $error("Ambient level out of range.");

    a_pready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready)
        else $error("Register port not ready.");

endmodule

bind peak_meter_with_ambient_level pmal_checker u_pmal_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data),
    .pready  (pready)
);

>>> verif/peak_meter_with_ambient_level_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Peak meter with ambient level testbench
// Drives sample and tick items with random gaps and back-pressure, predicts
// every report item from a behavioral model of the meter, and checks each
// result field by field across several register settings.
// ----------------------------------------------------------------------------
module peak_meter_with_ambient_level_test;
    import pmal_pkg::*;

    localparam int N_CH = 8;
    localparam int FULL = 1 << (SAMPLE_W - 1);

    logic                aclk = 1'b0;
    logic                aresetn = 1'b0;
    logic                s_valid = 1'b0;
    logic                s_ready;
    pmal_in_t            s_data = '0;
    logic                m_valid;
    logic                m_ready = 1'b0;
    pmal_out_t           m_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [3:0]          paddr = '0;
    logic [31:0]         pwdata = '0;
    logic [31:0]         prdata;
    logic                pready;

    peak_meter_with_ambient_level dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    pmal_in_t  pending_items[$];
    pmal_out_t expected_reports[$];
    int        errors = 0;
    int        send_idle = 0;
    int        recv_idle = 0;
    int        n_items = 0;
    int        n_ticks = 0;
    int        n_reports = 0;

    // Shadow of the registers and of the meter state.
    logic [CFG_CH_W-1:0]      cfg_channels = 4'd1;
    logic [ALPHA_W-1:0]       cfg_alpha_start = 16'd26214;
    logic [ALPHA_W-1:0]       cfg_alpha_steady = 16'd655;
    logic [TICKS_W-1:0]       cfg_start_ticks = 8'd6;
    logic [SAMPLE_W-1:0]      run_peak[N_CH];
    logic [SAMPLE_W-1:0]      last_peak[N_CH];
    int                       shown_channels = 0;
    logic signed [DB_W-1:0]   ambient = DB_FLOOR;
    int                       ticks_seen = 0;

    initial begin
        for (int i = 0; i < N_CH; i++) begin
            run_peak[i] = '0;
            last_peak[i] = '0;
        end
    end

    function automatic int effective_channels();
        return (cfg_channels > N_CH) ? N_CH : int'(cfg_channels);
    endfunction

    function automatic longint unsigned log2_q30(longint unsigned p);
        int e;
        longint unsigned x;
        longint unsigned frac;
        e = 0;
        frac = 0;
        while (e < 63 && (p >> (e + 1)) != 0) e++;
        x = p << (31 - e);
        for (int i = 0; i < FRAC_BITS; i++) begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000) begin
                frac = frac | 1;
                x = x >> 1;
            end
        end
        return (longint'(e) << FRAC_BITS) | frac;
    endfunction

    function automatic int level_q8(longint unsigned p);
        longint unsigned top;
        longint unsigned lg;
        longint unsigned log_dist;
        longint unsigned mag;
        if (p * 1000000 <= FULL) return int'(DB_FLOOR);
        top = longint'(SAMPLE_W - 1) << FRAC_BITS;
        lg = log2_q30(p);
        log_dist = (lg >= top) ? 0 : top - lg;
        mag = (log_dist * 101008905 + (64'd1 << 45)) >> 46;
        return -int'(mag);
    endfunction

    task automatic apply_item(input pmal_in_t it);
        logic [SAMPLE_W-1:0] mag;
        int                  p0;
        int                  lvl;
        longint              diff;
        longint              step;
        longint unsigned     prod;
        logic [ALPHA_W-1:0]  alpha;
        pmal_out_t           r;
        n_items++;
        if (it.operation == OP_SAMPLE) begin
            if (it.channel >= effective_channels()) return;
            mag = it.sample[SAMPLE_W-1] ? -it.sample : it.sample;
            if (mag > run_peak[it.channel]) run_peak[it.channel] = mag;
            if (it.buffer_end) begin
                last_peak[it.channel] = run_peak[it.channel];
                run_peak[it.channel] = '0;
                shown_channels = effective_channels();
            end
            return;
        end
        n_ticks++;
        p0 = (shown_channels > 0) ? int'(last_peak[0]) : 0;
        lvl = level_q8(p0);
        alpha = (ticks_seen < cfg_start_ticks) ? cfg_alpha_start : cfg_alpha_steady;
        if (lvl > int'(DB_GATE)) begin
            diff = longint'(lvl) - longint'(ambient);
            prod = longint'(diff < 0 ? -diff : diff) * alpha;
            step = longint'((prod + 32768) >> 16);
            ambient = ambient + DB_W'(diff < 0 ? -step : step);
        end
        if (ticks_seen < cfg_start_ticks) ticks_seen++;
        if (shown_channels == 0) begin
            r = '0;
            r.ambient_db = ambient;
            r.last_of_report = 1'b1;
            expected_reports.push_back(r);
        end else begin
            for (int i = 0; i < shown_channels; i++) begin
                r.out_channel = i[CH_FIELD_W-1:0];
                r.peak = last_peak[i];
                r.ambient_db = ambient;
                r.has_channels = 1'b1;
                r.last_of_report = (i + 1 == shown_channels);
                expected_reports.push_back(r);
            end
        end
    endtask

    // Driver: accepted items feed the predictor; the next item is offered
    // unless the random gap says otherwise.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_item(s_data);
            if (!s_valid || s_ready) begin
                if (pending_items.size() > 0 && $urandom_range(99) >= send_idle) begin
                    s_data <= pending_items.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                n_reports++;
                if (expected_reports.size() == 0) begin
                    $error("unexpected result item: %p", m_data);
                    errors++;
                end else begin
                    automatic pmal_out_t e = expected_reports.pop_front();
                    if (m_data.out_channel !== e.out_channel) begin
                        $error("out_channel exp %0d got %0d", e.out_channel, m_data.out_channel);
                        errors++;
                    end
                    if (m_data.peak !== e.peak) begin
                        $error("peak exp %0d got %0d", e.peak, m_data.peak);
                        errors++;
                    end
                    if (m_data.ambient_db !== e.ambient_db) begin
                        $error("ambient_db exp %0d got %0d", e.ambient_db, m_data.ambient_db);
                        errors++;
                    end
                    if (m_data.has_channels !== e.has_channels) begin
                        $error("has_channels exp %0b got %0b", e.has_channels,
                               m_data.has_channels);
                        errors++;
                    end
                    if (m_data.last_of_report !== e.last_of_report) begin
                        $error("last_of_report exp %0b got %0b", e.last_of_report,
                               m_data.last_of_report);
                        errors++;
                    end
                end
            end
            m_ready <= ($urandom_range(99) >= recv_idle);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input int value);
        @(posedge aclk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            REG_CHANNELS:     cfg_channels = CFG_CH_W'(value);
            REG_ALPHA_START:  cfg_alpha_start = ALPHA_W'(value);
            REG_ALPHA_STEADY: cfg_alpha_steady = ALPHA_W'(value);
            default:          cfg_start_ticks = TICKS_W'(value);
        endcase
    endtask

    task automatic configure(input int ch, input int a0, input int a1, input int nt);
        write_reg(REG_CHANNELS, ch);
        write_reg(REG_ALPHA_START, a0);
        write_reg(REG_ALPHA_STEADY, a1);
        write_reg(REG_START_TICKS, nt);
    endtask

    task automatic add_item(input logic op, input int ch, input int smp, input logic be);
        pmal_in_t it;
        it.operation = op;
        it.channel = CH_FIELD_W'(ch);
        it.sample = SAMPLE_W'(smp);
        it.buffer_end = be;
        pending_items.push_back(it);
    endtask

    task automatic drain();
        while (pending_items.size() > 0 || s_valid || expected_reports.size() > 0)
            @(posedge aclk);
        repeat (200) @(posedge aclk);
    endtask

    task automatic random_phase(input int count);
        int                   kind;
        int                   ch;
        logic signed [23:0]   v;
        for (int i = 0; i < count; i++) begin
            kind = $urandom_range(99);
            v = 24'($urandom);
            v = v >>> $urandom_range(23);
            if (kind < 75) begin
                ch = $urandom_range(((effective_channels() > 0) ? effective_channels() : 1) - 1);
                add_item(OP_SAMPLE, ch, v, $urandom_range(99) < 20);
            end else if (kind < 83) begin
                add_item(OP_SAMPLE, $urandom_range(7), v, 1'($urandom_range(1)));
            end else begin
                add_item(OP_TICK, $urandom_range(7), $urandom, 1'($urandom_range(1)));
            end
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part at reset settings.
        send_idle = 37;
        recv_idle = 81;
        add_item(OP_TICK, 0, 0, 1'b0);
        add_item(OP_SAMPLE, 0, -8388608, 1'b1);
        add_item(OP_TICK, 0, 0, 1'b0);
        add_item(OP_SAMPLE, 0, 8388607, 1'b1);
        add_item(OP_TICK, 7, -1, 1'b1);
        add_item(OP_SAMPLE, 0, 8, 1'b1);
        add_item(OP_TICK, 0, 0, 1'b0);
        add_item(OP_SAMPLE, 0, -9, 1'b1);
        add_item(OP_TICK, 0, 0, 1'b0);
        add_item(OP_SAMPLE, 0, 149, 1'b1);
        add_item(OP_TICK, 0, 0, 1'b0);
        add_item(OP_SAMPLE, 0, 150, 1'b1);
        add_item(OP_TICK, 0, 0, 1'b0);
        add_item(OP_SAMPLE, 0, -1, 1'b0);
        add_item(OP_SAMPLE, 0, 0, 1'b1);
        add_item(OP_SAMPLE, 5, 8388607, 1'b1);
        add_item(OP_TICK, 0, 0, 1'b0);
        drain();

        configure(8, 65535, 0, 0);
        add_item(OP_SAMPLE, 7, -8388608, 1'b1);
        add_item(OP_SAMPLE, 0, 4194304, 1'b1);
        add_item(OP_TICK, 0, 0, 1'b0);
        add_item(OP_TICK, 0, 0, 1'b0);
        random_phase(80);
        drain();

        configure(3, 0, 65535, 255);
        random_phase(80);
        drain();

        send_idle = 81;
        recv_idle = 37;
        configure(15, 12345, 999, 3);
        random_phase(80);
        drain();

        configure(0, 40000, 20, 1);
        random_phase(20);
        drain();
        write_reg(REG_CHANNELS, 5);
        random_phase(70);
        drain();

        send_idle = 0;
        recv_idle = 0;
        configure(1, 26214, 655, 6);
        random_phase(60);
        drain();

        configure(8, 30000, 3000, 10);
        random_phase(70);
        drain();

        $display("Covered %0d items, %0d report ticks and %0d result items", n_items,
                 n_ticks, n_reports);
        $display("over seven register settings, including zero and saturated counts.");
        if (errors == 0 && expected_reports.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> files.f
hdl/pmal_pkg.sv
hdl/pmal_front.sv
hdl/pmal_queue.sv
hdl/pmal_back.sv
hdl/peak_meter_with_ambient_level.sv
hdl/pmal_checker.sv
verif/peak_meter_with_ambient_level_test.sv
